>>> rtl/segint_pkg.sv
// shared types and constants for the segment intersection test
`timescale 1ns / 1ps
package segint_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // how the two segments relate
  typedef enum logic [1:0] {
    REL_CROSSING  = 2'd0,
    REL_PARALLEL  = 2'd1,
    REL_COLLINEAR = 2'd2
  } relation_t;

  // one result word
  typedef struct packed {
    logic      meets;
    relation_t relation;
  } result_t;

endpackage

>>> rtl/segment_intersection_test.sv
// top level of the segment intersection test: input stage, geometry, result stage
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  in_       in         in_valid / in_stall  eight signed coordinates, two segments
//  out_      out        out_valid/out_stall  meets (1 bit), relation (2 bits)
//
//  one word per cycle sustained while out_stall is low; an accepted word passes
//  through the input register and then the result register, with the
//  cross products, sign tests and overlap compare between them
//  synchronous active-low reset empties both stages; payload is not reset
//  a stalled result holds while the input stage still takes one more word,
//  so in_stall rises only when both stages are full and out_stall is high
//
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_meets,
  output segint_pkg::relation_t         out_relation
);
  import segint_pkg::*;

  localparam int unsigned CrossW = 2 * (COORD_WIDTH + 1) + 1;

  // input stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [COORD_WIDTH-1:0] a0x_r, a0y_r, a1x_r, a1y_r;
  logic signed [COORD_WIDTH-1:0] b0x_r, b0y_r, b1x_r, b1y_r;

  // result stage
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  result_t res_comb;

  logic signed [CrossW-1:0] den, t_num, u_num;

  logic s2_free, s1_move, s1_free, in_take;

  // handshake: result slot frees when empty or being taken
  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && s1_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (s2_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // coordinate capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      a0x_r <= in_first_start_x;
      a0y_r <= in_first_start_y;
      a1x_r <= in_first_end_x;
      a1y_r <= in_first_end_y;
      b0x_r <= in_second_start_x;
      b0y_r <= in_second_start_y;
      b1x_r <= in_second_end_x;
      b1y_r <= in_second_end_y;
    end
  end

  // denominator and numerators
  segint_cross #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cross (
    .a0x   (a0x_r),
    .a0y   (a0y_r),
    .a1x   (a1x_r),
    .a1y   (a1y_r),
    .b0x   (b0x_r),
    .b0y   (b0y_r),
    .b1x   (b1x_r),
    .b1y   (b1y_r),
    .den   (den),
    .t_num (t_num),
    .u_num (u_num)
  );

  // relation and meeting decision
  segint_classify #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_classify (
    .a0x   (a0x_r),
    .a0y   (a0y_r),
    .a1x   (a1x_r),
    .a1y   (a1y_r),
    .b0x   (b0x_r),
    .b0y   (b0y_r),
    .b1x   (b1x_r),
    .b1y   (b1y_r),
    .den   (den),
    .t_num (t_num),
    .u_num (u_num),
    .res   (res_comb)
  );

  // result register, loads only when the word moves on
  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_comb;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_meets    = res_r.meets;
  assign out_relation = res_r.relation;

  // a word in the input stage with a free result slot shows up next cycle
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("input stage word did not reach result stage");

  // back-pressure only when both stages hold a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // parallel distinct lines never meet
  a_parallel_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.relation == REL_PARALLEL)) |-> !res_r.meets)
    else $error("parallel segments reported as meeting");

  // with both stages empty, no new result appears
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !out_valid_r) |=> !out_valid_r)
    else $error("result appeared without an input word");

endmodule

>>> rtl/segint_cross.sv
// cross-product denominator and the t and u numerators
`timescale 1ns / 1ps
module segint_cross #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CrossW = 2 * (COORD_WIDTH + 1) + 1
) (
  input  logic signed [COORD_WIDTH-1:0] a0x,
  input  logic signed [COORD_WIDTH-1:0] a0y,
  input  logic signed [COORD_WIDTH-1:0] a1x,
  input  logic signed [COORD_WIDTH-1:0] a1y,
  input  logic signed [COORD_WIDTH-1:0] b0x,
  input  logic signed [COORD_WIDTH-1:0] b0y,
  input  logic signed [COORD_WIDTH-1:0] b1x,
  input  logic signed [COORD_WIDTH-1:0] b1y,
  output logic signed [CrossW-1:0]      den,
  output logic signed [CrossW-1:0]      t_num,
  output logic signed [CrossW-1:0]      u_num
);
  import segint_pkg::*;

  localparam int unsigned DiffW = COORD_WIDTH + 1;
  localparam int unsigned ProdW = 2 * DiffW;

  logic signed [DiffW-1:0] adx, ady, bdx, bdy, wx, wy;
  logic signed [ProdW-1:0] p_ab0, p_ab1, p_wb0, p_wb1, p_wa0, p_wa1;

  // edge vectors and the offset between start points, exact in one extra bit
  assign adx = DiffW'(a0x) - DiffW'(a1x);
  assign ady = DiffW'(a0y) - DiffW'(a1y);
  assign bdx = DiffW'(b0x) - DiffW'(b1x);
  assign bdy = DiffW'(b0y) - DiffW'(b1y);
  assign wx  = DiffW'(a0x) - DiffW'(b0x);
  assign wy  = DiffW'(a0y) - DiffW'(b0y);

  assign p_ab0 = ProdW'(adx) * ProdW'(bdy);
  assign p_ab1 = ProdW'(ady) * ProdW'(bdx);
  assign p_wb0 = ProdW'(wx)  * ProdW'(bdy);
  assign p_wb1 = ProdW'(wy)  * ProdW'(bdx);
  assign p_wa0 = ProdW'(wx)  * ProdW'(ady);
  assign p_wa1 = ProdW'(wy)  * ProdW'(adx);

  assign den   = CrossW'(p_ab0) - CrossW'(p_ab1);
  assign t_num = CrossW'(p_wb0) - CrossW'(p_wb1);
  assign u_num = CrossW'(p_wa0) - CrossW'(p_wa1);

endmodule

>>> rtl/segint_classify.sv
// range tests by sign and the collinear overlap check
`timescale 1ns / 1ps
module segint_classify #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CrossW = 2 * (COORD_WIDTH + 1) + 1
) (
  input  logic signed [COORD_WIDTH-1:0] a0x,
  input  logic signed [COORD_WIDTH-1:0] a0y,
  input  logic signed [COORD_WIDTH-1:0] a1x,
  input  logic signed [COORD_WIDTH-1:0] a1y,
  input  logic signed [COORD_WIDTH-1:0] b0x,
  input  logic signed [COORD_WIDTH-1:0] b0y,
  input  logic signed [COORD_WIDTH-1:0] b1x,
  input  logic signed [COORD_WIDTH-1:0] b1y,
  input  logic signed [CrossW-1:0]      den,
  input  logic signed [CrossW-1:0]      t_num,
  input  logic signed [CrossW-1:0]      u_num,
  output segint_pkg::result_t           res
);
  import segint_pkg::*;

  // p precedes or equals q, x first then y
  function automatic logic lex_le(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] qx,
    input logic signed [COORD_WIDTH-1:0] qy
  );
    logic le;
    if (px != qx) begin
      le = (px < qx);
    end else begin
      le = (py <= qy);
    end
    return le;
  endfunction

  // n/den within [0,1], den nonzero
  function automatic logic in_unit(
    input logic signed [CrossW-1:0] n,
    input logic signed [CrossW-1:0] dv
  );
    logic ok;
    if (dv > 0) begin
      ok = (n >= 0) && (n <= dv);
    end else begin
      ok = (n <= 0) && (n >= dv);
    end
    return ok;
  endfunction

  logic                          a_fwd, b_fwd;
  logic signed [COORD_WIDTH-1:0] alo_x, alo_y, ahi_x, ahi_y;
  logic signed [COORD_WIDTH-1:0] blo_x, blo_y, bhi_x, bhi_y;
  logic                          overlap, cross_hit;

  assign a_fwd = lex_le(a0x, a0y, a1x, a1y);
  assign b_fwd = lex_le(b0x, b0y, b1x, b1y);

  assign alo_x = a_fwd ? a0x : a1x;
  assign alo_y = a_fwd ? a0y : a1y;
  assign ahi_x = a_fwd ? a1x : a0x;
  assign ahi_y = a_fwd ? a1y : a0y;
  assign blo_x = b_fwd ? b0x : b1x;
  assign blo_y = b_fwd ? b0y : b1y;
  assign bhi_x = b_fwd ? b1x : b0x;
  assign bhi_y = b_fwd ? b1y : b0y;

  assign overlap   = lex_le(alo_x, alo_y, bhi_x, bhi_y) &&
                     lex_le(blo_x, blo_y, ahi_x, ahi_y);
  assign cross_hit = in_unit(t_num, den) && in_unit(u_num, den);

  always_comb begin
    if (den != '0) begin
      res.relation = REL_CROSSING;
      res.meets    = cross_hit;
    end else if ((t_num == '0) && (u_num == '0)) begin
      res.relation = REL_COLLINEAR;
      res.meets    = overlap;
    end else begin
      res.relation = REL_PARALLEL;
      res.meets    = 1'b0;
    end
  end

endmodule
